FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the vertex normal averager.
// Self-contained; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/tnva_pkg.sv
// Package of the vertex normal averager: widths, operation codes,
// sequencer states and table entry types. No dependencies.
package tnva_pkg;

    localparam int DEF_VERTEX_COUNT = 1024;

    localparam int IDX_W   = 10;
    localparam int COORD_W = 24;
    localparam int NORM_W  = 16;
    localparam int CNT_W   = 8;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int CROSS_W = 51;
    localparam int MAG_W   = 50;
    localparam int SCL_W   = 30;
    localparam int ACC_W   = 64;
    localparam int MUL_W   = 32;
    localparam int QUO_W   = 17;
    localparam int FRAC_SH = 15;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRITE,
        S_FINISH,
        S_READ,
        S_READW,
        S_FETCH,
        S_CROSS,
        S_ABS,
        S_SCALE,
        S_SQUARE,
        S_SQRT,
        S_FSET,
        S_DIV,
        S_FEND,
        S_ARD,
        S_AWAIT,
        S_AMUL,
        S_APREP,
        S_AEND,
        S_AWR
    } t_state;

    typedef logic [2:0][COORD_W-1:0] t_vertex;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
        logic [CNT_W-1:0]         count;
    } t_nrm_entry;

endpackage

FILE: hw/rtl/triangle_normal_vertex_average.sv
// Top level of the vertex normal averager: sequencer, shared datapath, tables.
// Depends on tnva_pkg, tnva_ram and assert_macros.svh.
//
// The block holds a table of vertices (Q12.12 coordinates) and, for each,
// a Q1.15 averaged normal with a saturating share count. A command is taken
// when start is high and busy is low; busy then stays high until the single
// result goes out, marked by o_valid for exactly one cycle. The receiver
// cannot stall, so sample the result ports whenever o_valid is high. Every
// command gives one result: a write gives all zeros, a read the stored
// normal and count, an add the face unit normal and the line flag; an
// unused code or an index at or beyond VERTEX_COUNT gives all zeros and
// changes nothing. An add runs on one shared 64-bit add/compare unit and
// one 32x32 multiplier: a 32-step square root and twelve 17-step
// restoring divisions (three for the face normal, three per corner for
// the averages) run on them one after another. Write normal_positive
// only while busy is low; o_cfg_ready follows !busy.
// Tables have no reset: read or use a vertex only after writing it.
`include "assert_macros.svh"

module triangle_normal_vertex_average #(
    parameter int VERTEX_COUNT = tnva_pkg::DEF_VERTEX_COUNT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_operation,
    input  logic [tnva_pkg::IDX_W-1:0]        i_vertex_index,
    input  logic signed [tnva_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [tnva_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [tnva_pkg::COORD_W-1:0] i_coord_z,
    input  logic [tnva_pkg::IDX_W-1:0]        i_corner_a,
    input  logic [tnva_pkg::IDX_W-1:0]        i_corner_b,
    input  logic [tnva_pkg::IDX_W-1:0]        i_corner_c,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_normal_positive,
    output logic                              o_valid,
    output logic                              o_is_line,
    output logic signed [tnva_pkg::NORM_W-1:0] o_normal_x,
    output logic signed [tnva_pkg::NORM_W-1:0] o_normal_y,
    output logic signed [tnva_pkg::NORM_W-1:0] o_normal_z,
    output logic [tnva_pkg::CNT_W-1:0]        o_share_count
);

    localparam int AW = $clog2(VERTEX_COUNT);
    localparam logic [16:0] VC_LIM = 17'(VERTEX_COUNT);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    tnva_pkg::t_state r_state, n_state;
    logic             r_valid;
    logic             r_pos;

    logic [2:0]       r_cnt;      // step or component index
    logic [1:0]       r_cidx;     // corner being averaged
    logic [4:0]       r_dcnt;     // divider step
    logic             r_avg;      // divider serves the averaging phase

    logic [tnva_pkg::IDX_W-1:0]       r_vi;
    tnva_pkg::t_vertex                r_vtx;
    logic [2:0][tnva_pkg::IDX_W-1:0]  r_corner;
    tnva_pkg::t_vertex                r_va, r_vb, r_vc;

    logic signed [tnva_pkg::ACC_W-1:0]   r_prod, r_acc;
    logic signed [tnva_pkg::CROSS_W-1:0] r_n   [3];
    logic [tnva_pkg::MAG_W-1:0]          r_mag [3];
    logic [2:0]                          r_neg;

    logic [tnva_pkg::ACC_W-1:0] r_rem, r_dvs;
    logic [62:0]                r_root, r_bit;
    logic [tnva_pkg::QUO_W-1:0] r_quo;

    logic signed [tnva_pkg::NORM_W-1:0] r_unit [3];
    logic signed [tnva_pkg::NORM_W-1:0] r_old  [3];
    logic signed [tnva_pkg::NORM_W-1:0] r_new  [3];
    logic [tnva_pkg::CNT_W-1:0]         r_oc;
    logic                               r_numneg;

    logic                               r_is_line;
    logic signed [tnva_pkg::NORM_W-1:0] r_nx, r_ny, r_nz;
    logic [tnva_pkg::CNT_W-1:0]         r_sc;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic vi_ok, corners_ok;
    logic [1:0] k;
    logic [1:0] fetch_sel;

    logic signed [tnva_pkg::EDGE_W-1:0] e1 [3];
    logic signed [tnva_pkg::EDGE_W-1:0] e2 [3];

    logic signed [tnva_pkg::MUL_W-1:0] m_a, m_b;
    logic signed [tnva_pkg::ACC_W-1:0] m_p;

    logic [tnva_pkg::ACC_W-1:0] u_a, u_b, u_res;
    logic                       u_sub, u_ge;
    logic [tnva_pkg::ACC_W:0]   u_sum;

    logic [tnva_pkg::MAG_W-1:0] mag_or;
    logic                       over;
    logic [30:0]                len;

    logic [8:0]                          dsum;
    logic signed [tnva_pkg::EDGE_W-1:0]  num;
    logic [tnva_pkg::EDGE_W-1:0]         num_mag;
    logic [tnva_pkg::NORM_W-1:0]         q_sat;
    logic [tnva_pkg::QUO_W-1:0]          q_neg;
    logic signed [tnva_pkg::NORM_W-1:0]  face_v, avg_v;

    tnva_pkg::t_vertex    crd_rdata;
    tnva_pkg::t_nrm_entry nrm_rdata, nrm_wdata;
    logic                 crd_we, nrm_we;
    logic [AW-1:0]        crd_raddr, nrm_waddr, nrm_raddr;

    assign busy        = (r_state != tnva_pkg::S_IDLE);
    assign o_cfg_ready = !busy;

    assign vi_ok      = ({7'b0, i_vertex_index} < VC_LIM);
    assign corners_ok = ({7'b0, i_corner_a} < VC_LIM) && ({7'b0, i_corner_b} < VC_LIM)
                     && ({7'b0, i_corner_c} < VC_LIM);

    assign k         = r_cnt[1:0];
    assign fetch_sel = (r_cnt[1:0] == 2'd3) ? 2'd2 : r_cnt[1:0];

    // Edge vectors b-a and c-a, one component each.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1[i] = $signed({r_vb[i][tnva_pkg::COORD_W-1], r_vb[i]})
                  - $signed({r_va[i][tnva_pkg::COORD_W-1], r_va[i]});
            e2[i] = $signed({r_vc[i][tnva_pkg::COORD_W-1], r_vc[i]})
                  - $signed({r_va[i][tnva_pkg::COORD_W-1], r_va[i]});
        end
    end

    // Shared multiplier: operands picked by the sequencer step.
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            tnva_pkg::S_CROSS: begin
                case (r_cnt)
                    3'd0:    begin m_a = 32'(e1[1]); m_b = 32'(e2[2]); end
                    3'd1:    begin m_a = 32'(e1[2]); m_b = 32'(e2[1]); end
                    3'd2:    begin m_a = 32'(e1[2]); m_b = 32'(e2[0]); end
                    3'd3:    begin m_a = 32'(e1[0]); m_b = 32'(e2[2]); end
                    3'd4:    begin m_a = 32'(e1[0]); m_b = 32'(e2[1]); end
                    3'd5:    begin m_a = 32'(e1[1]); m_b = 32'(e2[0]); end
                    default: begin m_a = '0;         m_b = '0;         end
                endcase
            end
            tnva_pkg::S_SQUARE: begin
                m_a = $signed({2'b00, r_mag[k][tnva_pkg::SCL_W-1:0]});
                m_b = $signed({2'b00, r_mag[k][tnva_pkg::SCL_W-1:0]});
            end
            tnva_pkg::S_AMUL: begin
                m_a = 32'(r_old[k]);
                m_b = $signed({24'b0, r_oc});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end
    assign m_p = m_a * m_b;

    assign len = (r_root == '0) ? 31'd1 : r_root[30:0];

    // Shared add / subtract / compare unit; carry out is A >= B on subtract.
    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
        unique case (r_state)
            tnva_pkg::S_CROSS: begin
                u_a = r_acc; u_b = r_prod; u_sub = 1'b1;
            end
            tnva_pkg::S_ABS: begin
                u_a = '0; u_b = 64'(r_n[k]); u_sub = 1'b1;
            end
            tnva_pkg::S_SQUARE: begin
                u_a = r_rem; u_b = r_prod; u_sub = 1'b0;
            end
            tnva_pkg::S_SQRT: begin
                u_a = r_rem; u_b = {1'b0, r_root | r_bit}; u_sub = 1'b1;
            end
            tnva_pkg::S_FSET: begin
                u_a   = 64'({r_mag[k][tnva_pkg::SCL_W-1:0], {tnva_pkg::FRAC_SH{1'b0}}});
                u_b   = 64'(len >> 1);
                u_sub = 1'b0;
            end
            tnva_pkg::S_DIV: begin
                u_a = r_rem; u_b = r_dvs; u_sub = 1'b1;
            end
            default: begin
                u_a = '0; u_b = '0; u_sub = 1'b0;
            end
        endcase
    end
    assign u_sum = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + 65'(u_sub);
    assign u_res = u_sum[tnva_pkg::ACC_W-1:0];
    assign u_ge  = u_sum[tnva_pkg::ACC_W];

    assign mag_or = r_mag[0] | r_mag[1] | r_mag[2];
    assign over   = |mag_or[tnva_pkg::MAG_W-1:tnva_pkg::SCL_W];

    // Averaging numerator normal*count + unit and its magnitude.
    assign dsum    = {1'b0, r_oc} + 9'd1;
    assign num     = $signed(r_prod[tnva_pkg::EDGE_W-1:0]) + 25'(r_unit[k]);
    assign num_mag = num[tnva_pkg::EDGE_W-1] ? 25'(-num) : 25'(num);

    // Quotient saturation and sign.
    assign q_sat  = (r_quo > 17'd32767) ? 16'd32767 : r_quo[tnva_pkg::NORM_W-1:0];
    assign q_neg  = 17'd0 - r_quo;
    assign face_v = (r_neg[k] ^ ~r_pos) ? $signed(16'(16'd0 - q_sat)) : $signed(q_sat);
    assign avg_v  = r_numneg ? $signed(q_neg[tnva_pkg::NORM_W-1:0]) : $signed(q_sat);

    // ---------------------------------------------------------------
    // Tables
    // ---------------------------------------------------------------
    assign crd_we    = (r_state == tnva_pkg::S_WRITE);
    assign crd_raddr = AW'(r_corner[fetch_sel]);

    assign nrm_we    = (r_state == tnva_pkg::S_WRITE) || (r_state == tnva_pkg::S_AWR);
    assign nrm_waddr = (r_state == tnva_pkg::S_WRITE) ? AW'(r_vi) : AW'(r_corner[r_cidx]);
    assign nrm_raddr = (r_state == tnva_pkg::S_READ) ? AW'(r_vi) : AW'(r_corner[r_cidx]);

    always_comb begin
        if (r_state == tnva_pkg::S_WRITE) begin
            nrm_wdata = '0;
        end else begin
            nrm_wdata.x     = r_new[0];
            nrm_wdata.y     = r_new[1];
            nrm_wdata.z     = r_new[2];
            nrm_wdata.count = (r_oc == 8'd255) ? r_oc : r_oc + 8'd1;
        end
    end

    tnva_ram #(
        .WIDTH ($bits(tnva_pkg::t_vertex)),
        .DEPTH (VERTEX_COUNT)
    ) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (crd_we),
        .i_waddr (AW'(r_vi)),
        .i_wdata (r_vtx),
        .i_raddr (crd_raddr),
        .o_rdata (crd_rdata)
    );

    tnva_ram #(
        .WIDTH ($bits(tnva_pkg::t_nrm_entry)),
        .DEPTH (VERTEX_COUNT)
    ) u_normal_ram (
        .i_clk   (i_clk),
        .i_we    (nrm_we),
        .i_waddr (nrm_waddr),
        .i_wdata (nrm_wdata),
        .i_raddr (nrm_raddr),
        .o_rdata (nrm_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tnva_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_pos   <= 1'b1;
        end else begin
            r_state <= n_state;
            // Strobe the result in the cycle busy drops.
            r_valid <= (r_state == tnva_pkg::S_WRITE) || (r_state == tnva_pkg::S_FINISH)
                    || (r_state == tnva_pkg::S_READW)
                    || ((r_state == tnva_pkg::S_AWR) && (r_cidx == 2'd2));
            if (i_cfg_valid && o_cfg_ready) begin
                r_pos <= i_cfg_normal_positive;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tnva_pkg::S_IDLE: begin
                if (start) begin
                    unique case (tnva_pkg::t_op'(i_operation))
                        tnva_pkg::OP_WRITE:
                            n_state = vi_ok ? tnva_pkg::S_WRITE : tnva_pkg::S_FINISH;
                        tnva_pkg::OP_READ:
                            n_state = vi_ok ? tnva_pkg::S_READ : tnva_pkg::S_FINISH;
                        tnva_pkg::OP_ADD:
                            n_state = corners_ok ? tnva_pkg::S_FETCH : tnva_pkg::S_FINISH;
                        default:
                            n_state = tnva_pkg::S_FINISH;
                    endcase
                end
            end
            tnva_pkg::S_WRITE:  n_state = tnva_pkg::S_IDLE;
            tnva_pkg::S_FINISH: n_state = tnva_pkg::S_IDLE;
            tnva_pkg::S_READ:   n_state = tnva_pkg::S_READW;
            tnva_pkg::S_READW:  n_state = tnva_pkg::S_IDLE;
            tnva_pkg::S_FETCH:  if (r_cnt == 3'd3) n_state = tnva_pkg::S_CROSS;
            tnva_pkg::S_CROSS:  if (r_cnt == 3'd6) n_state = tnva_pkg::S_ABS;
            tnva_pkg::S_ABS:    if (r_cnt == 3'd2) n_state = tnva_pkg::S_SCALE;
            tnva_pkg::S_SCALE:  if (!over) n_state = tnva_pkg::S_SQUARE;
            tnva_pkg::S_SQUARE: if (r_cnt == 3'd3) n_state = tnva_pkg::S_SQRT;
            tnva_pkg::S_SQRT:   if (r_bit[0]) n_state = tnva_pkg::S_FSET;
            tnva_pkg::S_FSET:   n_state = tnva_pkg::S_DIV;
            tnva_pkg::S_DIV: begin
                if (r_dcnt == 5'd16) begin
                    n_state = r_avg ? tnva_pkg::S_AEND : tnva_pkg::S_FEND;
                end
            end
            tnva_pkg::S_FEND:
                n_state = (r_cnt == 3'd2) ? tnva_pkg::S_ARD : tnva_pkg::S_FSET;
            tnva_pkg::S_ARD:    n_state = tnva_pkg::S_AWAIT;
            tnva_pkg::S_AWAIT:  n_state = tnva_pkg::S_AMUL;
            tnva_pkg::S_AMUL:   n_state = tnva_pkg::S_APREP;
            tnva_pkg::S_APREP:  n_state = tnva_pkg::S_DIV;
            tnva_pkg::S_AEND:
                n_state = (r_cnt == 3'd2) ? tnva_pkg::S_AWR : tnva_pkg::S_AMUL;
            tnva_pkg::S_AWR:
                n_state = (r_cidx == 2'd2) ? tnva_pkg::S_IDLE : tnva_pkg::S_ARD;
            default:            n_state = tnva_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            tnva_pkg::S_IDLE: begin
                // Hold the command for the whole run.
                if (start) begin
                    r_vi     <= i_vertex_index;
                    r_vtx    <= {i_coord_z, i_coord_y, i_coord_x};
                    r_corner <= {i_corner_c, i_corner_b, i_corner_a};
                    r_cnt    <= 3'd0;
                    r_cidx   <= 2'd0;
                end
            end
            tnva_pkg::S_WRITE, tnva_pkg::S_FINISH: begin
                r_is_line <= 1'b0;
                r_nx      <= '0;
                r_ny      <= '0;
                r_nz      <= '0;
                r_sc      <= '0;
            end
            tnva_pkg::S_READW: begin
                r_is_line <= 1'b0;
                r_nx      <= nrm_rdata.x;
                r_ny      <= nrm_rdata.y;
                r_nz      <= nrm_rdata.z;
                r_sc      <= nrm_rdata.count;
            end
            tnva_pkg::S_FETCH: begin
                // Read data is registered: it arrives in the cycle after its address.
                case (r_cnt)
                    3'd1:    r_va <= crd_rdata;
                    3'd2:    r_vb <= crd_rdata;
                    3'd3:    r_vc <= crd_rdata;
                    default: r_va <= r_va;
                endcase
                r_cnt <= (r_cnt == 3'd3) ? 3'd0 : r_cnt + 3'd1;
            end
            tnva_pkg::S_CROSS: begin
                // Every step but the last multiplies; odd steps hold the first product,
                // the even steps that follow subtract the second.
                if (r_cnt != 3'd6) begin
                    r_prod <= m_p;
                end
                case (r_cnt)
                    3'd1, 3'd3, 3'd5: r_acc  <= r_prod;
                    3'd2:             r_n[0] <= u_res[tnva_pkg::CROSS_W-1:0];
                    3'd4:             r_n[1] <= u_res[tnva_pkg::CROSS_W-1:0];
                    3'd6:             r_n[2] <= u_res[tnva_pkg::CROSS_W-1:0];
                    default:          r_acc  <= r_acc;
                endcase
                r_cnt <= (r_cnt == 3'd6) ? 3'd0 : r_cnt + 3'd1;
            end
            tnva_pkg::S_ABS: begin
                r_neg[k] <= r_n[k][tnva_pkg::CROSS_W-1];
                r_mag[k] <= r_n[k][tnva_pkg::CROSS_W-1] ? u_res[tnva_pkg::MAG_W-1:0]
                                                        : r_n[k][tnva_pkg::MAG_W-1:0];
                r_cnt    <= (r_cnt == 3'd2) ? 3'd0 : r_cnt + 3'd1;
            end
            tnva_pkg::S_SCALE: begin
                // Shift all three magnitudes until the largest fits 30 bits.
                if (over) begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end
                end else begin
                    r_rem <= '0;
                end
            end
            tnva_pkg::S_SQUARE: begin
                if (r_cnt != 3'd3) begin
                    r_prod <= m_p;
                end
                if (r_cnt != 3'd0) begin
                    r_rem <= u_res;
                end
                if (r_cnt == 3'd3) begin
                    r_cnt  <= 3'd0;
                    r_root <= '0;
                    r_bit  <= 63'(1) << 62;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
            tnva_pkg::S_SQRT: begin
                // One result bit per cycle, remainder method.
                if (u_ge) begin
                    r_rem  <= u_res;
                    r_root <= (r_root >> 1) | r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            tnva_pkg::S_FSET: begin
                r_rem  <= u_res;
                r_dvs  <= 64'(len) << 16;
                r_quo  <= '0;
                r_dcnt <= 5'd0;
                r_avg  <= 1'b0;
            end
            tnva_pkg::S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (u_ge) begin
                    r_rem <= u_res;
                end
                r_quo  <= {r_quo[tnva_pkg::QUO_W-2:0], u_ge};
                r_dvs  <= r_dvs >> 1;
                r_dcnt <= r_dcnt + 5'd1;
            end
            tnva_pkg::S_FEND: begin
                r_unit[k] <= face_v;
                r_cnt     <= (r_cnt == 3'd2) ? 3'd0 : r_cnt + 3'd1;
            end
            tnva_pkg::S_AWAIT: begin
                r_old[0] <= nrm_rdata.x;
                r_old[1] <= nrm_rdata.y;
                r_old[2] <= nrm_rdata.z;
                r_oc     <= nrm_rdata.count;
                r_cnt    <= 3'd0;
            end
            tnva_pkg::S_AMUL: begin
                r_prod <= m_p;
            end
            tnva_pkg::S_APREP: begin
                // Dividend |num| + d/2 rounds the quotient half away from zero.
                r_rem    <= 64'(num_mag) + 64'(dsum >> 1);
                r_numneg <= num[tnva_pkg::EDGE_W-1];
                r_dvs    <= 64'(dsum) << 16;
                r_quo    <= '0;
                r_dcnt   <= 5'd0;
                r_avg    <= 1'b1;
            end
            tnva_pkg::S_AEND: begin
                r_new[k] <= avg_v;
                r_cnt    <= (r_cnt == 3'd2) ? 3'd0 : r_cnt + 3'd1;
            end
            tnva_pkg::S_AWR: begin
                r_cidx <= r_cidx + 2'd1;
                if (r_cidx == 2'd2) begin
                    r_is_line <= (r_vb == r_vc);
                    r_nx      <= r_unit[0];
                    r_ny      <= r_unit[1];
                    r_nz      <= r_unit[2];
                    r_sc      <= '0;
                end
            end
            default: begin
                r_cidx <= r_cidx;
            end
        endcase
    end

    assign o_valid       = r_valid;
    assign o_is_line     = r_is_line;
    assign o_normal_x    = r_nx;
    assign o_normal_y    = r_ny;
    assign o_normal_z    = r_nz;
    assign o_share_count = r_sc;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_IMPL(a_div_steps, i_clk, i_rst_n, r_state == tnva_pkg::S_DIV, r_dcnt <= 5'd16)
    `ASSERT_IMPL(a_face_quo, i_clk, i_rst_n, r_state == tnva_pkg::S_FEND, r_quo <= 17'd32768)

endmodule

FILE: hw/rtl/tnva_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tnva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sim/triangle_normal_vertex_average_test.sv
// Self-checking testbench of the vertex normal averager: command driver,
// result monitor and a fixed-point face normal / running average predictor.
// Depends on tnva_pkg and the triangle_normal_vertex_average RTL.
module triangle_normal_vertex_average_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  VTX = 1024;
    localparam int  POOL = 24;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef logic [tnva_pkg::IDX_W-1:0]          t_idx;
    typedef logic signed [tnva_pkg::COORD_W-1:0] t_coord;
    typedef logic signed [tnva_pkg::NORM_W-1:0]  t_norm;
    typedef logic [tnva_pkg::CNT_W-1:0]          t_cnt;

    typedef struct {
        tnva_pkg::t_op op;
        t_idx          idx;
        t_coord        x, y, z;
        t_idx          a, b, c;
    } t_cmd;

    typedef struct {
        logic  is_line;
        t_norm nx, ny, nz;
        t_cnt  cnt;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_operation = '0;
    t_idx i_vertex_index = '0;
    t_coord i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    t_idx i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_normal_positive = 1'b0;
    logic o_valid, o_is_line;
    t_norm o_normal_x, o_normal_y, o_normal_z;
    t_cnt o_share_count;

    triangle_normal_vertex_average u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_vertex_index(i_vertex_index),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_corner_a(i_corner_a), .i_corner_b(i_corner_b), .i_corner_c(i_corner_c),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_normal_positive(i_cfg_normal_positive),
        .o_valid(o_valid), .o_is_line(o_is_line), .o_normal_x(o_normal_x),
        .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_share_count(o_share_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mirror of the vertex table and the direction register.
    int   vtx_coord [VTX][3];
    int   vtx_normal[VTX][3];
    int   vtx_count [VTX];
    logic keep_direction = 1'b1;

    t_cmd    cmd_queue[$];
    t_result results_due[$];
    int      errors = 0;
    int      n_accepted = 0, n_results = 0, n_adds = 0, n_lines = 0, n_cfg = 0;
    longint  cycles = 0;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res, probe;
        res = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v -= res + probe;
                res = (res >> 1) + probe;
            end else begin
                res >>= 1;
            end
            probe >>= 2;
        end
        return res;
    endfunction

    // Q1.15 face normal: exact cross product, scaled below 2^30, then divided
    // by the integer length (1 when the triangle is degenerate).
    task automatic face_unit(input int ia, input int ib, input int ic, output int unit[3]);
        longint e1[3], e2[3], n[3];
        longint unsigned m[3], maxm, sum, len, q;
        int s;
        for (int k = 0; k < 3; k++) begin
            e1[k] = longint'(vtx_coord[ib][k]) - vtx_coord[ia][k];
            e2[k] = longint'(vtx_coord[ic][k]) - vtx_coord[ia][k];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        maxm = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = (n[k] < 0) ? longint'(-n[k]) : n[k];
            if (m[k] > maxm) maxm = m[k];
        end
        s = 0;
        while ((maxm >> s) >= (64'd1 << 30)) s++;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] >>= s;
            sum += m[k] * m[k];
        end
        len = floor_sqrt(sum);
        if (len == 0) len = 1;
        for (int k = 0; k < 3; k++) begin
            q = (m[k] * 32768 + len / 2) / len;
            if (q > 32767) q = 32767;
            unit[k] = int'(q);
            if (n[k] < 0) unit[k] = -unit[k];
            if (!keep_direction) unit[k] = -unit[k];
        end
    endtask

    // Fold one face normal into a corner's running average.
    task automatic blend_into(input int vi, input int unit[3]);
        int c, d, num, mg, q;
        c = vtx_count[vi];
        d = c + 1;
        for (int k = 0; k < 3; k++) begin
            num = vtx_normal[vi][k] * c + unit[k];
            mg = (num < 0) ? -num : num;
            q = (mg + d / 2) / d;
            if (num < 0) q = -q;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            vtx_normal[vi][k] = q;
        end
        if (c < 255) vtx_count[vi] = c + 1;
    endtask

    task automatic apply_command(input t_cmd cm);
        t_result r;
        int unit[3];
        r = '{default: '0};
        case (cm.op)
            tnva_pkg::OP_WRITE: begin
                vtx_coord[cm.idx] = '{int'(cm.x), int'(cm.y), int'(cm.z)};
                vtx_normal[cm.idx] = '{0, 0, 0};
                vtx_count[cm.idx] = 0;
            end
            tnva_pkg::OP_READ: begin
                r.nx = t_norm'(vtx_normal[cm.idx][0]);
                r.ny = t_norm'(vtx_normal[cm.idx][1]);
                r.nz = t_norm'(vtx_normal[cm.idx][2]);
                r.cnt = t_cnt'(vtx_count[cm.idx]);
            end
            tnva_pkg::OP_ADD: begin
                face_unit(int'(cm.a), int'(cm.b), int'(cm.c), unit);
                r.is_line = (vtx_coord[cm.b] == vtx_coord[cm.c]);
                blend_into(int'(cm.a), unit);
                blend_into(int'(cm.b), unit);
                blend_into(int'(cm.c), unit);
                r.nx = t_norm'(unit[0]);
                r.ny = t_norm'(unit[1]);
                r.nz = t_norm'(unit[2]);
                n_adds++;
                if (r.is_line) n_lines++;
            end
            default: ;
        endcase
        results_due.push_back(r);
    endtask

    // Driver: take items in bursts with random gaps; hold a command until
    // the transfer happens.
    t_cmd cur_cmd;
    bit   took = 1'b0;
    int   burst_left = 1, gap_left = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n && start && !busy) begin
            apply_command(cur_cmd);
            n_accepted++;
            took = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!start || took) begin
            took = 1'b0;
            if (gap_left > 0 || !i_rst_n || cmd_queue.size() == 0) begin
                if (gap_left > 0) gap_left--;
                start <= 1'b0;
            end else begin
                cur_cmd = cmd_queue.pop_front();
                i_operation    <= cur_cmd.op;
                i_vertex_index <= cur_cmd.idx;
                i_coord_x      <= cur_cmd.x;
                i_coord_y      <= cur_cmd.y;
                i_coord_z      <= cur_cmd.z;
                i_corner_a     <= cur_cmd.a;
                i_corner_b     <= cur_cmd.b;
                i_corner_c     <= cur_cmd.c;
                start          <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    // Leave some stretches back to back.
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (results_due.size() == 0) begin
                $error("result with no command outstanding");
                errors++;
            end else begin
                e = results_due.pop_front();
                check_field("is_line", int'(e.is_line), int'(o_is_line));
                check_field("normal_x", int'(e.nx), int'(o_normal_x));
                check_field("normal_y", int'(e.ny), int'(o_normal_y));
                check_field("normal_z", int'(e.nz), int'(o_normal_z));
                check_field("share_count", int'(e.cnt), int'(o_share_count));
            end
        end
    end

    // Stimulus generation; tracks which vertices hold coordinates so that
    // no unwritten entry is ever read or used as a corner.
    bit written[VTX];
    int gen_coord[VTX][3];
    int used_idx[$];

    function automatic t_cmd blank_cmd(tnva_pkg::t_op op);
        t_cmd c;
        c = '{op: op, idx: '0, x: '0, y: '0, z: '0, a: '0, b: '0, c: '0};
        return c;
    endfunction

    task automatic push_write(input int vi, input int x, input int y, input int z);
        t_cmd c;
        c = blank_cmd(tnva_pkg::OP_WRITE);
        c.idx = t_idx'(vi);
        c.x = t_coord'(x);
        c.y = t_coord'(y);
        c.z = t_coord'(z);
        if (!written[vi]) used_idx.push_back(vi);
        written[vi] = 1'b1;
        gen_coord[vi] = '{x, y, z};
        cmd_queue.push_back(c);
    endtask

    task automatic push_add(input int a, input int b, input int cc);
        t_cmd c;
        c = blank_cmd(tnva_pkg::OP_ADD);
        c.a = t_idx'(a);
        c.b = t_idx'(b);
        c.c = t_idx'(cc);
        cmd_queue.push_back(c);
    endtask

    task automatic push_read(input int vi);
        t_cmd c;
        c = blank_cmd(tnva_pkg::OP_READ);
        c.idx = t_idx'(vi);
        cmd_queue.push_back(c);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
            1: return int'($urandom_range(0, 8192)) - 4096;
            2: return int'($urandom_range(0, 64)) - 32;
            default: return ($urandom_range(0, 1) ? 8388607 : -8388608)
                            - int'($urandom_range(0, 3)) * (($urandom_range(0, 1)) ? 1 : -1);
        endcase
    endfunction

    function automatic int pick_vertex();
        return used_idx[$urandom_range(0, used_idx.size() - 1)];
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || start || results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_direction(input logic value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_normal_positive <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        keep_direction = value;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        t_cmd c;
        int   vi, sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                // Mostly a small pool so averages build up; sometimes anywhere.
                vi = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, VTX - 1))
                                                 : int'($urandom_range(0, POOL - 1));
                if (used_idx.size() > 0 && $urandom_range(0, 4) == 0)
                    gen_coord[vi] = gen_coord[pick_vertex()];
                else
                    gen_coord[vi] = '{rand_coord(), rand_coord(), rand_coord()};
                push_write(vi, gen_coord[vi][0], gen_coord[vi][1], gen_coord[vi][2]);
            end else if (sel < 75) begin
                c = blank_cmd(tnva_pkg::OP_ADD);
                c.a = t_idx'(pick_vertex());
                c.b = t_idx'(pick_vertex());
                c.c = t_idx'(pick_vertex());
                if ($urandom_range(0, 9) == 0) c.c = c.b;
                if ($urandom_range(0, 9) == 0) c.a = c.b;
                push_add(int'(c.a), int'(c.b), int'(c.c));
            end else if (sel < 95) begin
                push_read(pick_vertex());
            end else begin
                // Unused code with random junk in every field.
                c = blank_cmd(tnva_pkg::OP_NONE);
                c.idx = t_idx'($urandom);
                c.x = t_coord'($urandom);
                c.y = t_coord'($urandom);
                c.z = t_coord'($urandom);
                c.a = t_idx'($urandom);
                c.b = t_idx'($urandom);
                c.c = t_idx'($urandom);
                cmd_queue.push_back(c);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme coordinates, full-scale cross product, degenerate
        // face, line case, repeated corner, reads and the unused code.
        push_write(0, 8388607, -8388608, 0);
        push_write(1, -8388608, 8388607, 8388607);
        push_write(2, 8388607, 8388607, -8388608);
        push_write(1023, 0, 0, 0);
        push_write(682, 12, -5, 7);
        push_write(341, 12, -5, 7);
        push_add(0, 1, 2);
        push_add(1023, 1023, 1023);
        push_add(1023, 682, 341);
        push_add(0, 0, 2);
        push_add(2, 1, 0);
        push_read(0);
        push_read(1);
        push_read(1023);
        push_read(682);
        cmd_queue.push_back(blank_cmd(tnva_pkg::OP_NONE));
        wait_drained();

        // Flip the direction; then drive three vertices past count saturation.
        write_direction(1'b0);
        push_write(3, 4096, 0, 0);
        push_write(4, 0, 4096, 0);
        push_write(5, 0, 0, 4096);
        for (int n = 0; n < 260; n++) push_add(3, 4, 5);
        push_read(3);
        push_read(5);
        wait_drained();

        write_direction(1'b1);
        random_phase(310);
        wait_drained();
        write_direction(1'b0);
        random_phase(310);
        wait_drained();
        write_direction(1'b1);
        random_phase(310);
        wait_drained();

        repeat (20) @(posedge i_clk);
        $display("covered %0d commands (%0d faces, %0d lines), %0d results, %0d cfg writes",
                 n_accepted, n_adds, n_lines, n_results, n_cfg);
        if (errors == 0 && results_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
